// ----- design/pcoc_pkg.sv -----
// ----------------------------------------------------------------------------
// Phase current offset calibration package
// Shared constants, types and the saturation function of the block.
// ----------------------------------------------------------------------------
package pcoc_pkg;

   // Calibration sequencing.
   localparam int SETTLE_PERIODS = 200;
   localparam int SETTLE_W       = 8;
   localparam int AVG_LOG2       = 5;
   localparam int AVG_LEN        = 1 << AVG_LOG2;
   localparam int WC_W           = AVG_LOG2 + 1;
   localparam int RAW_W          = 16;
   localparam int SUM_W          = RAW_W + AVG_LOG2;

   // Offsets and their acceptance window.
   localparam int OFS_W     = 14;
   localparam int OFS_LIMIT = 5120;
   localparam int AVG_MIN   = -32767;

   // Configuration widths and reset values.
   localparam int GAIN_W      = 16;
   localparam int TRIM_W      = 13;
   localparam int LIMIT_W     = 31;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd8;
   localparam logic [TRIM_W-1:0]  TRIM_RESET  = 13'd4096;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'h7FFF_FFFF;

   // Shared multiplier geometry.
   localparam int DIFF_W     = 17;
   localparam int A_W        = 19;
   localparam int B_W        = 17;
   localparam int PROD_W     = A_W + B_W;
   localparam int TRIM_FRAC  = 12;
   localparam int GAIN_SHIFT = 3;
   localparam int CUR_W      = 32;
   localparam int SAT_IN_W   = 34;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURRENT_GAIN  = 2'd0,
      CSR_V_GAIN_TRIM   = 2'd1,
      CSR_CURRENT_LIMIT = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_U,
      ST_MUL_TRIM,
      ST_MUL_V,
      ST_SAT_V,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_U,
      MUL_TRIM,
      MUL_V
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        cap_u;
      logic        cap_v;
   } dp_ctrl_type;

   typedef struct packed {
      logic signed [OFS_W-1:0] offset_u;
      logic signed [OFS_W-1:0] offset_v;
      logic                    fault;
      logic                    enable;
   } calib_stat_type;

   // Clamp a signed value to +/- lim.
   function automatic logic signed [CUR_W-1:0] sat_lim(
      input logic signed [SAT_IN_W-1:0] x,
      input logic [LIMIT_W-1:0]         lim
   );
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      logic signed [SAT_IN_W-1:0] r;
      hi = signed'({{(SAT_IN_W-LIMIT_W){1'b0}}, lim});
      lo = -hi;
      if (x > hi) begin
         r = hi;
      end else if (x < lo) begin
         r = lo;
      end else begin
         r = x;
      end
      return r[CUR_W-1:0];
   endfunction

endpackage

// ----- design/phase_current_offset_calibration_top.sv -----
// ----------------------------------------------------------------------------
// Phase current offset calibration, top level
// Per PWM period: offset removal, V gain trim, scaling and saturation of the
// phase currents, with idle-time offset averaging and a sticky offset fault.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  req_     in         req_tvalid/tready    tdata: adc_u, adc_v; tuser: motor_idle
//  rsp_     out        rsp_tvalid/tready    tdata: current_u/v/w; tuser: fault, enable
//  csr_     in         csr_valid/ready      csr_index, csr_data
//
// Each sample pair runs through the sequencer states in turn: the accepting
// state, three passes through the one shared multiplier (U times gain, V times
// trim, trimmed V times gain), V saturation and the output register write.
// Reset is synchronous and active high; it clears the sequencer, the output
// valid flag, all calibration state and restores the register defaults.
// The output register holds a finished result while rsp_tready is low; the
// next item can be accepted meanwhile, but its result waits in the final
// state until that register is free. Configuration writes are always taken.
//
module phase_current_offset_calibration_top
   import pcoc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [15:0] adc_u, [31:16] adc_v
   input  logic [0:0]            req_tuser,   // [0] motor_idle
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata,   // [31:0] current_u, [63:32] current_v,
                                              // [95:64] current_w
   output logic [1:0]            rsp_tuser,   // [0] offset_fault, [1] run_enable
   // Register write port.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   state_type state_ff, state_in;
   dp_ctrl_type ctrl;
   calib_stat_type stat;

   logic [GAIN_W-1:0]  gain_ff;
   logic [TRIM_W-1:0]  trim_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;
   logic        rsp_load;
   logic        req_xfer;

   logic signed [RAW_W-1:0] raw_u, raw_v;
   logic signed [CUR_W-1:0] cur_u, cur_v, cur_w;

   // Offset binary to two's complement is a flip of the top bit.
   assign raw_u    = signed'({~req_tdata[15], req_tdata[14:0]});
   assign raw_v    = signed'({~req_tdata[31], req_tdata[30:16]});
   assign req_xfer = req_tvalid && req_tready;

   // Configuration registers. Writes beyond the register list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         trim_ff  <= TRIM_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_CURRENT_GAIN:  gain_ff  <= csr_data[GAIN_W-1:0];
            CSR_V_GAIN_TRIM:   trim_ff  <= csr_data[TRIM_W-1:0];
            CSR_CURRENT_LIMIT: limit_ff <= csr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_MUL_U;
         ST_MUL_U:    state_in = ST_MUL_TRIM;
         ST_MUL_TRIM: state_in = ST_MUL_V;
         ST_MUL_V:    state_in = ST_SAT_V;
         ST_SAT_V:    state_in = ST_DONE;
         ST_DONE:     if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer: outputs. The product of the U pass is saturated while the
   // multiplier already works on the next operand pair.
   always_comb begin
      req_tready   = 1'b0;
      rsp_load     = 1'b0;
      ctrl.load    = 1'b0;
      ctrl.mul_en  = 1'b0;
      ctrl.mul_sel = MUL_U;
      ctrl.cap_u   = 1'b0;
      ctrl.cap_v   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctrl.load  = req_tvalid;
         end
         ST_MUL_U: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_U;
         end
         ST_MUL_TRIM: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_TRIM;
            ctrl.cap_u   = 1'b1;
         end
         ST_MUL_V: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_V;
         end
         ST_SAT_V: begin
            ctrl.cap_v = 1'b1;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   pcoc_datapath u_datapath (
      .clock    (clock),
      .ctrl     (ctrl),
      .raw_u    (raw_u),
      .raw_v    (raw_v),
      .offset_u (stat.offset_u),
      .offset_v (stat.offset_v),
      .gain     (gain_ff),
      .trim     (trim_ff),
      .limit    (limit_ff),
      .cur_u    (cur_u),
      .cur_v    (cur_v),
      .cur_w    (cur_w)
   );

   // Calibration updates on the accepting edge; the datapath captures its
   // differences on the same edge, so it still sees the previous offsets.
   pcoc_calib u_calib (
      .clock  (clock),
      .reset  (reset),
      .accept (req_xfer),
      .raw_u  (raw_u),
      .raw_v  (raw_v),
      .idle   (req_tuser[0]),
      .stat   (stat)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {cur_w, cur_v, cur_u};
         rsp_user_ff <= {stat.enable, stat.fault};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // An accepted item always starts the multiplier sequence.
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_MUL_U)
      else $error("accepted item did not start the multiply sequence");

   // A fault is only raised when an averaging window completes, which also
   // sets the run flag.
   a_fault_has_enable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[1])
      else $error("offset fault reported without run enable");

   // The fault flag is sticky across results.
   a_fault_sticky : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |=> rsp_tuser[0])
      else $error("sticky offset fault cleared");

endmodule

// ----- design/pcoc_calib.sv -----
// ----------------------------------------------------------------------------
// Offset calibration
// Settle counter, raw sample averaging, offset store and fault tracking.
// ----------------------------------------------------------------------------
module pcoc_calib
   import pcoc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic signed [RAW_W-1:0] raw_u,
   input  logic signed [RAW_W-1:0] raw_v,
   input  logic                    idle,
   output calib_stat_type          stat
);

   logic [SETTLE_W-1:0]     settle_ff, settle_in;
   logic signed [SUM_W-1:0] sum_u_ff, sum_u_in;
   logic signed [SUM_W-1:0] sum_v_ff, sum_v_in;
   logic [WC_W-1:0]         wc_ff, wc_in;
   logic signed [OFS_W-1:0] ofs_u_ff, ofs_u_in;
   logic signed [OFS_W-1:0] ofs_v_ff, ofs_v_in;
   logic [2:0]              bad_ff, bad_in;
   logic                    fault_ff, fault_in;
   logic                    enable_ff, enable_in;

   logic [SETTLE_W-1:0]     settle_inc;
   logic signed [SUM_W-1:0] acc_u, acc_v;
   logic [WC_W-1:0]         wc_inc;
   logic signed [RAW_W-1:0] avg_u, avg_v;
   logic signed [RAW_W-1:0] fix_u, fix_v;
   logic                    good;

   always_comb begin
      settle_inc = (settle_ff < SETTLE_W'(SETTLE_PERIODS)) ? settle_ff + 1'b1 : settle_ff;
      acc_u      = sum_u_ff + SUM_W'(raw_u);
      acc_v      = sum_v_ff + SUM_W'(raw_v);
      wc_inc     = wc_ff + 1'b1;
      avg_u      = acc_u[SUM_W-1:AVG_LOG2];
      avg_v      = acc_v[SUM_W-1:AVG_LOG2];
      // The most negative average is pulled in by one so it can be negated.
      fix_u = (avg_u == RAW_W'(AVG_MIN - 1)) ? RAW_W'(AVG_MIN) : avg_u;
      fix_v = (avg_v == RAW_W'(AVG_MIN - 1)) ? RAW_W'(AVG_MIN) : avg_v;
      good  = (fix_u < RAW_W'(OFS_LIMIT)) && (fix_u > -RAW_W'(OFS_LIMIT)) &&
              (fix_v < RAW_W'(OFS_LIMIT)) && (fix_v > -RAW_W'(OFS_LIMIT));

      settle_in = settle_ff;
      sum_u_in  = sum_u_ff;
      sum_v_in  = sum_v_ff;
      wc_in     = wc_ff;
      ofs_u_in  = ofs_u_ff;
      ofs_v_in  = ofs_v_ff;
      bad_in    = bad_ff;
      fault_in  = fault_ff;
      enable_in = enable_ff;

      if (accept) begin
         if (!idle) begin
            settle_in = '0;
         end else if (settle_inc < SETTLE_W'(SETTLE_PERIODS)) begin
            settle_in = settle_inc;
            sum_u_in  = '0;
            sum_v_in  = '0;
            wc_in     = '0;
         end else begin
            settle_in = settle_inc;
            sum_u_in  = acc_u;
            sum_v_in  = acc_v;
            wc_in     = wc_inc;
            if (wc_inc == WC_W'(AVG_LEN)) begin
               sum_u_in  = '0;
               sum_v_in  = '0;
               wc_in     = '0;
               enable_in = 1'b1;
               if (good) begin
                  ofs_u_in = fix_u[OFS_W-1:0];
                  ofs_v_in = fix_v[OFS_W-1:0];
                  bad_in   = '0;
               end else if (bad_ff > 3'd5) begin
                  fault_in  = 1'b1;
                  bad_in    = '0;
                  settle_in = '0;
               end else begin
                  bad_in = bad_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
         sum_u_ff  <= '0;
         sum_v_ff  <= '0;
         wc_ff     <= '0;
         ofs_u_ff  <= '0;
         ofs_v_ff  <= '0;
         bad_ff    <= '0;
         fault_ff  <= 1'b0;
         enable_ff <= 1'b0;
      end else begin
         settle_ff <= settle_in;
         sum_u_ff  <= sum_u_in;
         sum_v_ff  <= sum_v_in;
         wc_ff     <= wc_in;
         ofs_u_ff  <= ofs_u_in;
         ofs_v_ff  <= ofs_v_in;
         bad_ff    <= bad_in;
         fault_ff  <= fault_in;
         enable_ff <= enable_in;
      end
   end

   assign stat.offset_u = ofs_u_ff;
   assign stat.offset_v = ofs_v_ff;
   assign stat.fault    = fault_ff;
   assign stat.enable   = enable_ff;

endmodule

// ----- design/pcoc_datapath.sv -----
// ----------------------------------------------------------------------------
// Current scaling datapath
// One shared signed multiplier with a registered product, plus saturation.
// ----------------------------------------------------------------------------
module pcoc_datapath
   import pcoc_pkg::*;
(
   input  logic                      clock,
   input  dp_ctrl_type               ctrl,
   input  logic signed [RAW_W-1:0]   raw_u,
   input  logic signed [RAW_W-1:0]   raw_v,
   input  logic signed [OFS_W-1:0]   offset_u,
   input  logic signed [OFS_W-1:0]   offset_v,
   input  logic [GAIN_W-1:0]         gain,
   input  logic [TRIM_W-1:0]         trim,
   input  logic [LIMIT_W-1:0]        limit,
   output logic signed [CUR_W-1:0]   cur_u,
   output logic signed [CUR_W-1:0]   cur_v,
   output logic signed [CUR_W-1:0]   cur_w
);

   logic signed [DIFF_W-1:0] du_ff, du_in;
   logic signed [DIFF_W-1:0] dv_ff, dv_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [CUR_W-1:0]  cu_ff, cv_ff;

   logic signed [A_W-1:0]    a_op;
   logic signed [B_W-1:0]    b_op;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [A_W-1:0]    dv_trim;
   logic signed [SAT_IN_W-1:0] scaled;
   logic signed [SAT_IN_W-1:0] neg_sum;

   assign du_in   = DIFF_W'(raw_u) - DIFF_W'(offset_u);
   assign dv_in   = DIFF_W'(raw_v) - DIFF_W'(offset_v);
   assign dv_trim = prod_ff[TRIM_FRAC+A_W-1:TRIM_FRAC];
   assign scaled  = SAT_IN_W'(signed'(prod_ff[PROD_W-1:GAIN_SHIFT]));

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_U: begin
            a_op = A_W'(du_ff);
            b_op = signed'({1'b0, gain});
         end
         MUL_TRIM: begin
            a_op = A_W'(dv_ff);
            b_op = signed'({{(B_W-TRIM_W){1'b0}}, trim});
         end
         MUL_V: begin
            a_op = dv_trim;
            b_op = signed'({1'b0, gain});
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
      prod_in = a_op * b_op;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         du_ff <= du_in;
         dv_ff <= dv_in;
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.cap_u) begin
         cu_ff <= sat_lim(scaled, limit);
      end
      if (ctrl.cap_v) begin
         cv_ff <= sat_lim(scaled, limit);
      end
   end

   assign neg_sum = -(SAT_IN_W'(cu_ff) + SAT_IN_W'(cv_ff));
   assign cur_u   = cu_ff;
   assign cur_v   = cv_ff;
   assign cur_w   = sat_lim(neg_sum, limit);

endmodule

// ----- test/tb_phase_current_offset_calibration_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the phase current offset calibration top level
// Streams sample pairs through the block and compares every result transfer
// against an in-bench model of offset removal, trim, scaling, saturation and
// idle-time offset averaging, under changing register settings and backpressure.
// ----------------------------------------------------------------------------
module tb_phase_current_offset_calibration_top;
   import pcoc_pkg::*;

   // A transfer on any of the three channels has to show up within this many quiet cycles.
   localparam int QUIET_LIMIT  = 4000;
   // Extra wait after the last pending result, so the block settles.
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 480;
   // Converter code of a zero current.
   localparam int MID_CODE     = 32768;

   // Content of one averaging window of idle periods.
   typedef enum int {
      WIN_GOOD,
      WIN_BAD,
      WIN_EDGE,
      WIN_FLOOR
   } window_kind_type;

   typedef struct {
      logic signed [CUR_W-1:0] cur_u;
      logic signed [CUR_W-1:0] cur_v;
      logic signed [CUR_W-1:0] cur_w;
      logic                    fault;
      logic                    enable;
   } phase_currents_type;

   // Predicts the result of each accepted sample pair and checks the results.
   class phase_current_checker;
      logic [GAIN_W-1:0]  gain;
      logic [TRIM_W-1:0]  trim;
      logic [LIMIT_W-1:0] limit;
      int settle_cnt;
      int sum_u;
      int sum_v;
      int win_cnt;
      int ofs_u;
      int ofs_v;
      int bad_cnt;
      bit fault;
      bit enable;
      phase_currents_type pending_currents[$];
      int failures;

      function new();
         gain       = GAIN_RESET;
         trim       = TRIM_RESET;
         limit      = LIMIT_RESET;
         settle_cnt = 0;
         sum_u      = 0;
         sum_v      = 0;
         win_cnt    = 0;
         ofs_u      = 0;
         ofs_v      = 0;
         bad_cnt    = 0;
         fault      = 1'b0;
         enable     = 1'b0;
         failures   = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_CURRENT_GAIN:  gain  = value[GAIN_W-1:0];
            CSR_V_GAIN_TRIM:   trim  = value[TRIM_W-1:0];
            CSR_CURRENT_LIMIT: limit = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_current(longint x);
         longint lim;
         lim = longint'(limit);
         if (x > lim) return lim;
         if (x < -lim) return -lim;
         return x;
      endfunction

      function void note_sample(logic [RAW_W-1:0] adc_u, logic [RAW_W-1:0] adc_v,
                                logic idle);
         int raw_u;
         int raw_v;
         int avg_u;
         int avg_v;
         longint trimmed;
         longint cu;
         longint cv;
         longint cw;
         phase_currents_type e;
         raw_u = int'(adc_u) - MID_CODE;
         raw_v = int'(adc_v) - MID_CODE;

         // Currents use the offsets from before this period; >>> floors.
         cu = clamp_current(((longint'(raw_u) - ofs_u) * longint'(gain)) >>> GAIN_SHIFT);
         trimmed = ((longint'(raw_v) - ofs_v) * longint'(trim)) >>> TRIM_FRAC;
         cv = clamp_current((trimmed * longint'(gain)) >>> GAIN_SHIFT);
         cw = clamp_current(-(cu + cv));

         if (!idle) begin
            settle_cnt = 0;
         end else begin
            if (settle_cnt < SETTLE_PERIODS) settle_cnt++;
            if (settle_cnt < SETTLE_PERIODS) begin
               sum_u   = 0;
               sum_v   = 0;
               win_cnt = 0;
            end else begin
               sum_u += raw_u;
               sum_v += raw_v;
               win_cnt++;
               if (win_cnt >= AVG_LEN) begin
                  avg_u = sum_u >>> AVG_LOG2;
                  avg_v = sum_v >>> AVG_LOG2;
                  if (avg_u == -MID_CODE) avg_u = AVG_MIN;
                  if (avg_v == -MID_CODE) avg_v = AVG_MIN;
                  sum_u   = 0;
                  sum_v   = 0;
                  win_cnt = 0;
                  enable  = 1'b1;
                  if ((avg_u < 0 ? -avg_u : avg_u) < OFS_LIMIT &&
                      (avg_v < 0 ? -avg_v : avg_v) < OFS_LIMIT) begin
                     ofs_u   = avg_u;
                     ofs_v   = avg_v;
                     bad_cnt = 0;
                  end else if (bad_cnt > 5) begin
                     fault      = 1'b1;
                     bad_cnt    = 0;
                     settle_cnt = 0;
                  end else begin
                     bad_cnt++;
                  end
               end
            end
         end

         e.cur_u  = cu[CUR_W-1:0];
         e.cur_v  = cv[CUR_W-1:0];
         e.cur_w  = cw[CUR_W-1:0];
         e.fault  = fault;
         e.enable = enable;
         pending_currents.push_back(e);
      endfunction

      function void compare_field(string name, longint want, longint seen);
         if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            failures++;
         end
      endfunction

      function void check_currents(logic [95:0] data, logic [1:0] flags);
         phase_currents_type e;
         if (pending_currents.size() == 0) begin
            $display("%0t: result transfer with nothing pending, got %h / %b",
                     $time, data, flags);
            failures++;
            return;
         end
         e = pending_currents.pop_front();
         compare_field("current_u", e.cur_u, signed'(data[31:0]));
         compare_field("current_v", e.cur_v, signed'(data[63:32]));
         compare_field("current_w", e.cur_w, signed'(data[95:64]));
         compare_field("offset_fault", e.fault, flags[0]);
         compare_field("run_enable", e.enable, flags[1]);
      endfunction
   endclass

   // Every input has a known value from time zero on.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [31:0]           req_tdata  = '0;
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   csr_index_type         csr_index  = CSR_CURRENT_GAIN;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [95:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_ready;

   phase_current_checker currents_sb;
   int send_gap_pct = 0;
   int stall_pct    = 0;
   int items_sent   = 0;
   int quiet_cycles = 0;

   phase_current_offset_calibration_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // The receiver drops tready at random, cycle by cycle, so stalls can land on
   // any step of the block's sequence.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Result checking and the watchdog. Outputs are sampled at the edge, before
   // any of this edge's updates, so the check sees exactly what was transferred.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            currents_sb.check_currents(rsp_tdata, rsp_tuser);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // One sample pair. The sender may hold tvalid low for a few cycles first;
   // otherwise tvalid stays high from one transfer into the next.
   task automatic send_sample(logic [RAW_W-1:0] adc_u, logic [RAW_W-1:0] adc_v,
                              logic idle);
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {adc_v, adc_u};
      req_tuser  <= idle;
      do @(posedge clock); while (!req_tready);
      currents_sb.note_sample(adc_u, adc_v, idle);
      items_sent++;
   endtask

   // Stop sending and wait until every predicted result has been transferred.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (currents_sb.pending_currents.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers, then pokes the unused index with junk,
   // which the block has to ignore. Only called while the block is idle.
   task automatic configure(logic [CSR_DATA_W-1:0] gain_word,
                            logic [CSR_DATA_W-1:0] trim_word,
                            logic [CSR_DATA_W-1:0] limit_word);
      csr_index_type         idx [4];
      logic [CSR_DATA_W-1:0] word [4];
      idx  = '{CSR_CURRENT_GAIN, CSR_V_GAIN_TRIM, CSR_CURRENT_LIMIT, CSR_UNUSED};
      word = '{gain_word, trim_word, limit_word, $urandom()};
      csr_valid <= 1'b1;
      foreach (idx[k]) begin
         csr_index <= idx[k];
         csr_data  <= word[k];
         do @(posedge clock); while (!csr_ready);
         currents_sb.write_register(idx[k], word[k]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [RAW_W-1:0] near_code(int center, int spread);
      int v;
      v = center + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[RAW_W-1:0];
   endfunction

   // A window average this far from zero is always rejected.
   function automatic int far_center();
      int f;
      f = int'($urandom_range(5200, 32000));
      return $urandom_range(1) ? MID_CODE + f : MID_CODE - f;
   endfunction

   // Constant codes right at the acceptance boundary and at full scale.
   function automatic int edge_center();
      case ($urandom_range(5))
         0: return MID_CODE + OFS_LIMIT - 1;
         1: return MID_CODE + OFS_LIMIT;
         2: return MID_CODE - OFS_LIMIT;
         3: return MID_CODE - OFS_LIMIT + 1;
         4: return 0;
         default: return 65535;
      endcase
   endfunction

   task automatic idle_window(window_kind_type kind);
      int cen_u;
      int cen_v;
      int spread;
      spread = 0;
      case (kind)
         WIN_GOOD: begin
            cen_u  = MID_CODE + int'($urandom_range(9000)) - 4500;
            cen_v  = MID_CODE + int'($urandom_range(9000)) - 4500;
            spread = int'($urandom_range(400));
         end
         WIN_BAD: begin
            // Either phase alone, or both, out of the acceptance window.
            cen_u  = MID_CODE + int'($urandom_range(6000)) - 3000;
            cen_v  = MID_CODE + int'($urandom_range(6000)) - 3000;
            spread = int'($urandom_range(150));
            case ($urandom_range(2))
               0: cen_u = far_center();
               1: cen_v = far_center();
               default: begin
                  cen_u = far_center();
                  cen_v = far_center();
               end
            endcase
         end
         WIN_EDGE: begin
            cen_u = edge_center();
            cen_v = edge_center();
         end
         default: begin
            // All-zero codes average to the most negative value, which the
            // block pulls in by one before judging it.
            cen_u = 0;
            cen_v = 0;
         end
      endcase
      repeat (AVG_LEN) send_sample(near_code(cen_u, spread), near_code(cen_v, spread), 1'b1);
   endtask

   // A full calibration sequence: one busy period, the settling time, then
   // averaging windows. The last settling period already accumulates, hence
   // one idle period fewer than the settle length before the windows.
   task automatic calibrate(int windows, bit to_fault);
      window_kind_type kind;
      int pick;
      send_sample(RAW_W'($urandom_range(65535)), RAW_W'($urandom_range(65535)), 1'b0);
      repeat (SETTLE_PERIODS - 1)
         send_sample(RAW_W'($urandom_range(65535)), RAW_W'($urandom_range(65535)), 1'b1);
      for (int w = 0; w < windows; w++) begin
         pick = int'($urandom_range(9));
         if (to_fault) kind = (w == 0) ? WIN_FLOOR : WIN_BAD;
         else if (pick < 6) kind = WIN_GOOD;
         else if (pick < 8) kind = WIN_BAD;
         else if (pick < 9) kind = WIN_EDGE;
         else kind = WIN_FLOOR;
         idle_window(kind);
      end
   endtask

   task automatic noise_run(int n);
      repeat (n)
         send_sample(RAW_W'($urandom_range(65535)), RAW_W'($urandom_range(65535)),
                     $urandom_range(99) < 30);
   endtask

   // An idle stretch that ends before settling is over.
   task automatic broken_settle();
      send_sample(RAW_W'($urandom_range(65535)), RAW_W'($urandom_range(65535)), 1'b0);
      repeat ($urandom_range(1, SETTLE_PERIODS - 1))
         send_sample(RAW_W'($urandom_range(65535)), RAW_W'($urandom_range(65535)), 1'b1);
      send_sample(RAW_W'($urandom_range(65535)), RAW_W'($urandom_range(65535)), 1'b0);
   endtask

   // One random phase: drain, new register values and idling rates, then a
   // mix of calibration sequences, short idle stretches and busy noise.
   task automatic run_phase(int gap_pct, int stall, logic [CSR_DATA_W-1:0] gain_word,
                            logic [CSR_DATA_W-1:0] trim_word,
                            logic [CSR_DATA_W-1:0] limit_word, bit with_fault);
      int target;
      drain_results();
      configure(gain_word, trim_word, limit_word);
      send_gap_pct = gap_pct;
      stall_pct    = stall;
      target       = items_sent + PHASE_ITEMS;
      // Seven rejected averages in a row raise the sticky fault.
      if (with_fault) calibrate(7, 1'b1);
      while (items_sent < target) begin
         case ($urandom_range(9))
            0, 1, 2: noise_run(int'($urandom_range(5, 40)));
            3:       broken_settle();
            default: calibrate(int'($urandom_range(1, 4)), 1'b0);
         endcase
      end
   endtask

   initial begin
      currents_sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Register defaults first, full-scale codes.
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'hFFFF, 16'hFFFF, 1'b0);
      send_sample(16'h8000, 16'h8000, 1'b0);
      send_sample(16'h0000, 16'hFFFF, 1'b1);
      send_sample(16'hFFFF, 16'h0000, 1'b1);

      // Largest gain, trim and limit; all data bits set, upper ones ignored.
      drain_results();
      configure('1, '1, '1);
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'hFFFF, 16'hFFFF, 1'b0);
      send_sample(16'h0000, 16'hFFFF, 1'b1);
      send_sample(16'hFFFF, 16'h0000, 1'b0);
      send_sample(16'h7FFF, 16'h8001, 1'b0);

      // A zero limit forces every current to zero.
      drain_results();
      configure(32'd65535, 32'd8191, 32'd0);
      send_sample(16'h0000, 16'hFFFF, 1'b0);
      send_sample(16'd12345, 16'd54321, 1'b1);

      // Zero gain, small limit.
      drain_results();
      configure(32'd0, 32'd4096, 32'd1000);
      send_sample(16'h0000, 16'hFFFF, 1'b0);
      send_sample(16'd40000, 16'd20000, 1'b0);

      // Zero trim removes phase V entirely.
      drain_results();
      configure(32'd65535, 32'd0, 32'h7FFF_FFFF);
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'hFFFF, 16'hFFFF, 1'b0);

      // Random part. Each phase begins by draining, so the sender pauses
      // until nothing is outstanding before the registers change.
      run_phase(20, 56, $urandom_range(1, 64), $urandom_range(3600, 4600), $urandom(), 1'b0);
      run_phase(56, 20, $urandom(), $urandom(), $urandom_range(0, 200000), 1'b1);
      run_phase(0, 0, 32'h0000_FFFF, 32'h0000_1FFF, 32'h7FFF_FFFF, 1'b0);

      drain_results();
      if (currents_sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
